@@ design/scar_pkg.sv @@
// Shared constants, delay line layout tables and saturation helpers
// for the stereo comb/allpass reverb. No dependencies.
`default_nettype none
package scar_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WORD_W     = 24;
	localparam int FRAC_W     = WORD_W - SAMPLE_W;
	localparam int COMB_LINES = 16;
	localparam int AP_LINES   = 8;
	localparam int COMB_AW    = 15;
	localparam int AP_AW      = 12;
	localparam int COMB_DEPTH = 32768;
	localparam int AP_DEPTH   = 4096;
	localparam int CPOS_W     = 11;
	localparam int APOS_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_GAIN = 3'd0,
		REG_COMB_FB    = 3'd1,
		REG_DAMPING    = 3'd2,
		REG_WET_MAIN   = 3'd3,
		REG_WET_CROSS  = 3'd4,
		REG_DRY_LEVEL  = 3'd5
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] Q15_ONE = 16'd32768;

	// left and right lines interleaved: even entries left, odd entries right
	localparam logic [CPOS_W-1:0] COMB_LEN [COMB_LINES] = '{
		11'd1116, 11'd1139, 11'd1188, 11'd1211, 11'd1277, 11'd1300, 11'd1356, 11'd1379,
		11'd1422, 11'd1445, 11'd1491, 11'd1514, 11'd1557, 11'd1580, 11'd1617, 11'd1640
	};
	localparam logic [COMB_AW-1:0] COMB_START [COMB_LINES] = '{
		15'd0,     15'd1116,  15'd2255,  15'd3443,  15'd4654,  15'd5931,  15'd7231,  15'd8587,
		15'd9966,  15'd11388, 15'd12833, 15'd14324, 15'd15838, 15'd17395, 15'd18975, 15'd20592
	};
	localparam logic [APOS_W-1:0] AP_LEN [AP_LINES] = '{
		10'd556, 10'd579, 10'd441, 10'd464, 10'd341, 10'd364, 10'd225, 10'd248
	};
	localparam logic [AP_AW-1:0] AP_START [AP_LINES] = '{
		12'd0, 12'd556, 12'd1135, 12'd1576, 12'd2040, 12'd2381, 12'd2745, 12'd2970
	};

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [47:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 48'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -48'sd8388608)
			r = 24'sh800000;
		else
			r = v[WORD_W-1:0];
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [47:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 48'sd32767)
			r = 16'sh7FFF;
		else if (v < -48'sd32768)
			r = 16'sh8000;
		else
			r = v[SAMPLE_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/stereo_comb_allpass_reverb.sv @@
// Stereo comb/allpass reverb top level: sequencer, delay memories, filters, mix.
// Depends on scar_pkg.
//
//  channel   signals                                     dir  beat
//  input     in_valid/in_ready, left_sample/right_sample  in   one stereo frame
//  output    out_valid/out_ready, left_out/right_out      out  one stereo frame
//  config    cfg_we, cfg_index, cfg_data                  in   one register write
//
// From accept to result a frame runs 16 comb reads through the comb memory
// port, the comb pipeline, 8 allpass reads, the mix products and the output
// register. After reset a clearing pass over every comb memory address zeroes
// both delay memories; in_ready stays low meanwhile. A result waiting on
// out_ready holds the last step of the frame; the next frame is taken as soon
// as the result is registered.
`default_nettype none
module stereo_comb_allpass_reverb (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [scar_pkg::SAMPLE_W-1:0]   left_sample,
	input  wire logic signed [scar_pkg::SAMPLE_W-1:0]   right_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [scar_pkg::SAMPLE_W-1:0]        left_out,
	output logic signed [scar_pkg::SAMPLE_W-1:0]        right_out,
	input  wire logic                                   cfg_we,
	input  wire logic [scar_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [scar_pkg::CFG_W-1:0]             cfg_data
);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_t;

	localparam logic [4:0] CNT_COMB_END = 5'd16;
	localparam logic [4:0] CNT_AP_END   = 5'd24;
	localparam logic [4:0] CNT_MIX      = 5'd25;
	localparam logic [4:0] CNT_LAST     = 5'd26;

	state_t state_q;
	logic [4:0] cnt_q;
	logic [scar_pkg::COMB_AW-1:0] clr_q;

	logic [scar_pkg::CFG_W-1:0] gain_q, fb_q, damp_q, wm_q, wc_q, dry_q;
	logic [scar_pkg::CFG_W-1:0] cfg_q15;

	logic signed [scar_pkg::SAMPLE_W-1:0] l_q, r_q;
	logic signed [33:0] feed_prod_q;
	logic signed [47:0] feed_ext;
	logic signed [scar_pkg::WORD_W-1:0] feed;

	logic [scar_pkg::CPOS_W-1:0] cpos_q [scar_pkg::COMB_LINES];
	logic [scar_pkg::APOS_W-1:0] apos_q [scar_pkg::AP_LINES];
	logic signed [scar_pkg::WORD_W-1:0] lp_q [scar_pkg::COMB_LINES];

	logic signed [scar_pkg::WORD_W-1:0] comb_mem [scar_pkg::COMB_DEPTH];
	logic signed [scar_pkg::WORD_W-1:0] ap_mem [scar_pkg::AP_DEPTH];
	logic signed [scar_pkg::WORD_W-1:0] crd_q, ard_q;
	logic                               cwe, awe;
	logic [scar_pkg::COMB_AW-1:0]       cwa, cra;
	logic [scar_pkg::AP_AW-1:0]         awa, ara;
	logic signed [scar_pkg::WORD_W-1:0] cwd, awd;

	logic comb_issue, ap_issue;
	logic [3:0] ck;
	logic [2:0] aj;
	logic [scar_pkg::CPOS_W-1:0] cpos_cur, cpos_nxt;
	logic [scar_pkg::APOS_W-1:0] apos_cur, apos_nxt;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [3:0] k_s1, k_s2;
	logic [scar_pkg::COMB_AW-1:0] ca_s1, ca_s2, ca_s3, ca_s4;
	logic signed [40:0] m1_s2, m2_s2, m3_s4;
	logic signed [scar_pkg::WORD_W-1:0] filt, filt_s3, comb_wr;
	logic [scar_pkg::CFG_W-1:0] one_minus_d;

	logic av_s1;
	logic [2:0] aj_s1;
	logic [scar_pkg::AP_AW-1:0] aa_s1;
	logic signed [scar_pkg::WORD_W-1:0] ap_x, ap_y, ap_new;

	logic signed [27:0] accl_q, accr_q;

	logic signed [40:0] plm_q, prc_q, pld_q, prm_q, plc_q, prd_q;
	logic signed [47:0] mix_l, mix_r;
	logic last_stall, in_acc;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid & in_ready;
	assign last_stall = (cnt_q == CNT_LAST) & out_valid & ~out_ready;
	assign cfg_q15    = (cfg_data > scar_pkg::Q15_ONE) ? scar_pkg::Q15_ONE : cfg_data;
	assign one_minus_d = scar_pkg::Q15_ONE - damp_q;

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
			gain_q  <= 16'd492;
			fb_q    <= 16'd27525;
			damp_q  <= 16'd6554;
			wm_q    <= 16'd16384;
			wc_q    <= 16'd0;
			dry_q   <= 16'd0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					scar_pkg::REG_INPUT_GAIN: gain_q <= cfg_q15;
					scar_pkg::REG_COMB_FB:    fb_q   <= cfg_q15;
					scar_pkg::REG_DAMPING:    damp_q <= cfg_q15;
					scar_pkg::REG_WET_MAIN:   wm_q   <= cfg_data;
					scar_pkg::REG_WET_CROSS:  wc_q   <= cfg_data;
					scar_pkg::REG_DRY_LEVEL:  dry_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_RUN && cnt_q == CNT_LAST && !last_stall)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == CNT_LAST) begin
						if (!last_stall)
							state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer issue decode
	assign comb_issue = (state_q == ST_RUN) && (cnt_q < CNT_COMB_END);
	assign ap_issue   = (state_q == ST_RUN) && (cnt_q >= CNT_COMB_END) && (cnt_q < CNT_AP_END);
	assign ck       = cnt_q[3:0];
	assign aj       = cnt_q[2:0];
	assign cpos_cur = cpos_q[ck];
	assign cpos_nxt = (cpos_cur + 1'b1 == scar_pkg::COMB_LEN[ck]) ? '0 : cpos_cur + 1'b1;
	assign apos_cur = apos_q[aj];
	assign apos_nxt = (apos_cur + 1'b1 == scar_pkg::AP_LEN[aj]) ? '0 : apos_cur + 1'b1;
	assign cra = scar_pkg::COMB_START[ck] + scar_pkg::COMB_AW'(cpos_cur);
	assign ara = scar_pkg::AP_START[aj] + scar_pkg::AP_AW'(apos_cur);

	// feed from the held frame
	assign feed_ext = (48'(feed_prod_q) <<< scar_pkg::FRAC_W) + 48'sd16384;
	assign feed     = scar_pkg::sat_word(feed_ext >>> 15);

	// comb datapath
	assign filt = scar_pkg::sat_word((48'(m1_s2) + 48'(m2_s2) + 48'sd16384) >>> 15);
	assign comb_wr = scar_pkg::sat_word(48'(feed) + ((48'(m3_s4) + 48'sd16384) >>> 15));

	// allpass datapath
	assign ap_x   = scar_pkg::sat_word(48'(aj_s1[0] ? accr_q : accl_q));
	assign ap_y   = scar_pkg::sat_word(48'(ard_q) - 48'(ap_x));
	assign ap_new = scar_pkg::sat_word(48'(ap_x) + ((48'(ard_q) + 48'sd1) >>> 1));

	assign mix_l = 48'(plm_q) + 48'(prc_q) + 48'(pld_q) + 48'sd2097152;
	assign mix_r = 48'(prm_q) + 48'(plc_q) + 48'(prd_q) + 48'sd2097152;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			av_s1 <= 1'b0;
			for (int i = 0; i < scar_pkg::COMB_LINES; i++) begin
				cpos_q[i] <= '0;
				lp_q[i]   <= '0;
			end
			for (int i = 0; i < scar_pkg::AP_LINES; i++)
				apos_q[i] <= '0;
		end else begin
			v_s1  <= comb_issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			av_s1 <= ap_issue;
			if (comb_issue)
				cpos_q[ck] <= cpos_nxt;
			if (ap_issue)
				apos_q[aj] <= apos_nxt;
			if (v_s2)
				lp_q[k_s2] <= filt;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			l_q         <= left_sample;
			r_q         <= right_sample;
			feed_prod_q <= (34'(left_sample) + 34'(right_sample)) * $signed({18'd0, gain_q});
			accl_q      <= '0;
			accr_q      <= '0;
		end else if (v_s1) begin
			if (k_s1[0])
				accr_q <= accr_q + 28'(crd_q);
			else
				accl_q <= accl_q + 28'(crd_q);
		end else if (av_s1) begin
			if (aj_s1[0])
				accr_q <= 28'(ap_y);
			else
				accl_q <= 28'(ap_y);
		end
		k_s1  <= ck;
		ca_s1 <= cra;
		k_s2  <= k_s1;
		ca_s2 <= ca_s1;
		m1_s2 <= 41'(crd_q) * $signed({25'd0, one_minus_d});
		m2_s2 <= 41'(lp_q[k_s1]) * $signed({25'd0, damp_q});
		ca_s3   <= ca_s2;
		filt_s3 <= filt;
		ca_s4 <= ca_s3;
		m3_s4 <= 41'(filt_s3) * $signed({25'd0, fb_q});
		aj_s1 <= aj;
		aa_s1 <= ara;
		if (cnt_q == CNT_MIX) begin
			plm_q <= 41'(scar_pkg::sat_word(48'(accl_q))) * $signed({25'd0, wm_q});
			prc_q <= 41'(scar_pkg::sat_word(48'(accr_q))) * $signed({25'd0, wc_q});
			prm_q <= 41'(scar_pkg::sat_word(48'(accr_q))) * $signed({25'd0, wm_q});
			plc_q <= 41'(scar_pkg::sat_word(48'(accl_q))) * $signed({25'd0, wc_q});
			pld_q <= 41'($signed({l_q, 8'd0})) * $signed({25'd0, dry_q});
			prd_q <= 41'($signed({r_q, 8'd0})) * $signed({25'd0, dry_q});
		end
		if (state_q == ST_RUN && cnt_q == CNT_LAST && !last_stall) begin
			left_out  <= scar_pkg::sat_sample(mix_l >>> 22);
			right_out <= scar_pkg::sat_sample(mix_r >>> 22);
		end
	end

	// memory ports: clearing pass or pipeline write-back
	assign cwe = (state_q == ST_CLEAR) | v_s4;
	assign cwa = (state_q == ST_CLEAR) ? clr_q : ca_s4;
	assign cwd = (state_q == ST_CLEAR) ? '0 : comb_wr;
	assign awe = (state_q == ST_CLEAR) | av_s1;
	assign awa = (state_q == ST_CLEAR) ? clr_q[scar_pkg::AP_AW-1:0] : aa_s1;
	assign awd = (state_q == ST_CLEAR) ? '0 : ap_new;

	always_ff @(posedge clk) begin
		if (cwe)
			comb_mem[cwa] <= cwd;
		crd_q <= comb_mem[cra];
	end

	always_ff @(posedge clk) begin
		if (awe)
			ap_mem[awa] <= awd;
		ard_q <= ap_mem[ara];
	end

endmodule
`default_nettype wire

@@ sim/stereo_comb_allpass_reverb_check.sv @@
// Checker for the stereo comb/allpass reverb: follows register writes and frame beats,
// predicts each output frame from its own delay line model and compares it.
// Depends on scar_pkg.
module stereo_comb_allpass_reverb_check (
	input  wire logic                          clk,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic signed [15:0]            left_sample,
	input  wire logic signed [15:0]            right_sample,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic signed [15:0]            left_out,
	input  wire logic signed [15:0]            right_out,
	input  wire logic                          cfg_we,
	input  wire logic [scar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [scar_pkg::CFG_W-1:0]    cfg_data,
	output int                                 errors,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} frame_t;

	localparam int SPREAD = 23;
	localparam int COMB_BASE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int AP_BASE [4] = '{556, 441, 341, 225};

	logic signed [23:0] comb_words [32768];
	logic signed [23:0] ap_words [4096];
	int comb_at [16];
	int comb_size [16];
	int comb_base_addr [16];
	int ap_at [8];
	int ap_size [8];
	int ap_base_addr [8];
	longint lowpass [16];
	logic [15:0] regs [6];
	frame_t frames_due [$];

	initial begin
		int b;
		errors = 0;
		b = 0;
		foreach (comb_words[i]) comb_words[i] = '0;
		foreach (ap_words[i]) ap_words[i] = '0;
		for (int i = 0; i < 16; i++) begin
			comb_size[i] = COMB_BASE[i / 2] + ((i % 2) ? SPREAD : 0);
			comb_base_addr[i] = b;
			b += comb_size[i];
			comb_at[i] = 0;
			lowpass[i] = 0;
		end
		b = 0;
		for (int i = 0; i < 8; i++) begin
			ap_size[i] = AP_BASE[i / 2] + ((i % 2) ? SPREAD : 0);
			ap_base_addr[i] = b;
			b += ap_size[i];
			ap_at[i] = 0;
		end
		regs[scar_pkg::REG_INPUT_GAIN] = 16'd492;
		regs[scar_pkg::REG_COMB_FB] = 16'd27525;
		regs[scar_pkg::REG_DAMPING] = 16'd6554;
		regs[scar_pkg::REG_WET_MAIN] = 16'd16384;
		regs[scar_pkg::REG_WET_CROSS] = 16'd0;
		regs[scar_pkg::REG_DRY_LEVEL] = 16'd0;
	end

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint unit_gain(scar_pkg::cfg_reg_t r);
		return regs[r] > 16'd32768 ? 32768 : longint'(regs[r]);
	endfunction

	function automatic longint comb_line(int k, longint feed);
		int p, a;
		longint o, f, d;
		p = comb_at[k];
		a = (comb_base_addr[k] + p) % 32768;
		o = comb_words[a];
		d = unit_gain(scar_pkg::REG_DAMPING);
		f = clip(round_sh(o * (32768 - d) + lowpass[k] * d, 15), 24);
		lowpass[k] = f;
		comb_words[a] = 24'(clip(feed + round_sh(f * unit_gain(scar_pkg::REG_COMB_FB), 15), 24));
		comb_at[k] = (p + 1 >= comb_size[k]) ? 0 : p + 1;
		return o;
	endfunction

	function automatic longint allpass_line(int k, longint x);
		int p, a;
		longint h, y;
		p = ap_at[k];
		a = (ap_base_addr[k] + p) % 4096;
		h = ap_words[a];
		y = clip(h - x, 24);
		ap_words[a] = 24'(clip(x + round_sh(h, 1), 24));
		ap_at[k] = (p + 1 >= ap_size[k]) ? 0 : p + 1;
		return y;
	endfunction

	function automatic frame_t reverb_frame(longint l, longint r);
		longint feed, acl, acr, ol, orr;
		frame_t f;
		acl = 0;
		acr = 0;
		feed = clip(round_sh((l + r) * unit_gain(scar_pkg::REG_INPUT_GAIN) * 256, 15), 24);
		for (int i = 0; i < 8; i++) begin
			acl += comb_line(2 * i, feed);
			acr += comb_line(2 * i + 1, feed);
		end
		acl = clip(acl, 24);
		acr = clip(acr, 24);
		for (int i = 0; i < 4; i++) begin
			acl = allpass_line(2 * i, acl);
			acr = allpass_line(2 * i + 1, acr);
		end
		ol = acl * longint'(regs[scar_pkg::REG_WET_MAIN])
			+ acr * longint'(regs[scar_pkg::REG_WET_CROSS])
			+ l * 256 * longint'(regs[scar_pkg::REG_DRY_LEVEL]);
		orr = acr * longint'(regs[scar_pkg::REG_WET_MAIN])
			+ acl * longint'(regs[scar_pkg::REG_WET_CROSS])
			+ r * 256 * longint'(regs[scar_pkg::REG_DRY_LEVEL]);
		f.left = 16'(clip(round_sh(ol, 22), 16));
		f.right = 16'(clip(round_sh(orr, 22), 16));
		return f;
	endfunction

	always @(posedge clk) begin
		frame_t want;
		if (cfg_we && cfg_index <= scar_pkg::REG_DRY_LEVEL)
			regs[cfg_index] = cfg_data;
		if (in_valid && in_ready)
			frames_due.push_back(reverb_frame(longint'(left_sample), longint'(right_sample)));
		if (out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output beat %0d/%0d", left_out, right_out);
			end else begin
				want = frames_due.pop_front();
				if (want.left !== left_out || want.right !== right_out) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0d/%0d, got %0d/%0d",
							want.left, want.right, left_out, right_out);
				end
			end
		end
		pending = frames_due.size();
	end

	initial pending = 0;

endmodule

@@ sim/stereo_comb_allpass_reverb_test.sv @@
// Top of the reverb testbench: clock, reset, register settings, frame stimulus and
// output back-pressure. Uses scar_pkg, stereo_comb_allpass_reverb and its checker.
module stereo_comb_allpass_reverb_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [scar_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [scar_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] left_sample = '0;
	logic signed [15:0] right_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic cfg_we = 1'b0;
	logic [scar_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [scar_pkg::CFG_W-1:0] cfg_data = '0;
	int errors;
	int pending;
	int cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	stereo_comb_allpass_reverb i_dut (.*);

	stereo_comb_allpass_reverb_check i_check (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output side back-pressure
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic set_reg(logic [scar_pkg::CFG_IDX_W-1:0] idx, logic [scar_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_regs(logic [15:0] g, fb, dm, wm, wc, dr);
		set_reg(scar_pkg::REG_INPUT_GAIN, g);
		set_reg(scar_pkg::REG_COMB_FB, fb);
		set_reg(scar_pkg::REG_DAMPING, dm);
		set_reg(scar_pkg::REG_WET_MAIN, wm);
		set_reg(scar_pkg::REG_WET_CROSS, wc);
		set_reg(scar_pkg::REG_DRY_LEVEL, dr);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r);
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 511)) - 16'd256;
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom_range(0, 8191)) - 16'd4096;
		endcase
	endfunction

	task automatic run_frames(int n);
		for (int i = 0; i < n; i++)
			send_frame(pick_sample(), pick_sample());
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(16'sh7FFF, 16'sh7FFF);
		send_frame(-16'sh8000, -16'sh8000);
		send_frame(16'sh7FFF, -16'sh8000);
		send_frame(16'sh0000, 16'sh0000);
		send_frame(16'sh5555, 16'shAAAA);
		send_frame(16'shAAAA, 16'sh5555);
		send_frame(16'sh0001, -16'sh0001);
		in_valid <= 1'b0;
		@(posedge clk);
		drain();

		// over-range gains clamp, freeze, full wet and dry, spare indexes ignored
		load_regs(16'hFFFF, 16'd32768, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		set_reg(IDX_SPARE_LO, 16'h0000);
		set_reg(IDX_SPARE_HI, 16'hFFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_frame(i[0] ? 16'sh7FFF : -16'sh8000, i[1] ? 16'sh7FFF : -16'sh8000);
		hold_req = 1'b1;
		run_frames(300);
		drain();

		load_regs(16'd0, 16'd0, 16'd32768, 16'd0, 16'd0, 16'd0);
		run_frames(150);
		drain();

		load_regs(16'd492, 16'd27525, 16'd6554, 16'd16384, 16'd0, 16'd0);
		run_frames(350);
		drain();

		load_regs(16'($urandom), 16'($urandom_range(20000, 32768)),
			16'($urandom_range(0, 32768)), 16'($urandom), 16'($urandom), 16'($urandom));
		run_frames(350);
		drain();

		load_regs(16'd40000, 16'd50000, 16'd33000, 16'd30000, 16'd9000, 16'd20000);
		quiet = 1'b1;
		run_frames(350);
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/scar_pkg.sv
design/stereo_comb_allpass_reverb.sv
sim/stereo_comb_allpass_reverb_check.sv
sim/stereo_comb_allpass_reverb_test.sv
